// ===== rtl/core/b64enc_pkg.sv =====
`timescale 1ns / 1ps
package b64enc_pkg;

  localparam int QueueDepthDefault = 2;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [7:0] c3;
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
    logic       stream_end;
  } group_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/b64enc_front.sv =====
`timescale 1ns / 1ps
module b64enc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tlast,
  input  logic                queue_full,
  output logic                push,
  output b64enc_pkg::group_t  push_group
);
  import b64enc_pkg::*;

  logic [7:0] held_first;
  logic [7:0] held_second;
  logic [1:0] held_count;
  logic       accept;
  logic [5:0] s0, s1, s2, s3;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && (s_tlast || held_count[1]);

  always_comb begin
    s0 = 6'd0;
    s1 = 6'd0;
    s2 = 6'd0;
    s3 = 6'd0;
    push_group = '0;
    push_group.stream_end = s_tlast;
    if (held_count == 2'd0) begin
      s0 = s_tdata[7:2];
      s1 = {s_tdata[1:0], 4'd0};
      push_group.c0 = b64_char(s0);
      push_group.c1 = b64_char(s1);
      push_group.c2 = PadChar;
      push_group.c3 = PadChar;
    end else if (held_count == 2'd1) begin
      s0 = held_first[7:2];
      s1 = {held_first[1:0], s_tdata[7:4]};
      s2 = {s_tdata[3:0], 2'd0};
      push_group.c0 = b64_char(s0);
      push_group.c1 = b64_char(s1);
      push_group.c2 = b64_char(s2);
      push_group.c3 = PadChar;
    end else begin
      s0 = held_first[7:2];
      s1 = {held_first[1:0], held_second[7:4]};
      s2 = {held_second[3:0], s_tdata[7:6]};
      s3 = s_tdata[5:0];
      push_group.c0 = b64_char(s0);
      push_group.c1 = b64_char(s1);
      push_group.c2 = b64_char(s2);
      push_group.c3 = b64_char(s3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_first  <= 8'd0;
      held_second <= 8'd0;
      held_count  <= 2'd0;
    end else if (accept) begin
      if (push) begin
        held_first  <= 8'd0;
        held_second <= 8'd0;
        held_count  <= 2'd0;
      end else if (held_count == 2'd0) begin
        held_first <= s_tdata;
        held_count <= 2'd1;
      end else begin
        held_second <= s_tdata;
        held_count  <= 2'd2;
      end
    end
  end

endmodule

// ===== rtl/core/b64enc_fifo.sv =====
`timescale 1ns / 1ps
module b64enc_fifo #(
  parameter int Depth = b64enc_pkg::QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64enc_pkg::group_t  push_group,
  input  logic                pop,
  output b64enc_pkg::group_t  pop_group,
  output logic                full,
  output logic                empty
);
  import b64enc_pkg::*;

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  group_t          slots [Depth];
  logic [IdxW-1:0] wr_ptr;
  logic [IdxW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == CntW'(Depth));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_group = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IdxW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IdxW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/b64enc_back.sv =====
`timescale 1ns / 1ps
module b64enc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                queue_empty,
  input  b64enc_pkg::group_t  pop_group,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);
  import b64enc_pkg::*;

  group_t     grp;
  logic       busy;
  logic [1:0] idx;
  logic       done;

  assign done     = m_tready && (idx == 2'd3);
  assign pop      = !queue_empty && (!busy || done);
  assign m_tvalid = busy;
  assign m_tlast  = (idx == 2'd3);
  assign m_tuser  = grp.stream_end && (idx == 2'd3);

  always_comb begin
    case (idx)
      2'd0:    m_tdata = grp.c0;
      2'd1:    m_tdata = grp.c1;
      2'd2:    m_tdata = grp.c2;
      default: m_tdata = grp.c3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      grp <= pop_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && m_tready) begin
      if (idx == 2'd3) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/base64_stream_encoder.sv =====
`timescale 1ns / 1ps
// Streaming base64 encoder with the standard alphabet and '=' padding.
// The input channel takes one raw byte per transaction; tlast marks the
// final byte of a message. The output channel gives one ASCII character per
// transaction: tlast marks the fourth character of each group and tuser marks
// the last character of the message.
// Every third byte, or the final byte, completes a group of four characters.
// A completed group is written into the group queue and then loaded into the
// output group register before its first character appears; the other three
// follow one per cycle while tready is high. Input bytes are taken one per
// cycle while the group queue has room; the character output runs at one per
// cycle while tready is high; the output serializer limits the sustained rate.
// A stalled receiver holds the current character; the input keeps accepting
// bytes until the group queue is full, then deasserts tready.
// Synchronous reset drops pending bytes and queued groups.
module base64_stream_encoder #(
  parameter int QueueDepth = b64enc_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // final_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast,   // run_last
  output logic       m_tuser    // [0] stream_end
);
  import b64enc_pkg::*;

  group_t push_group;
  group_t pop_group;
  logic   push;
  logic   pop;
  logic   queue_full;
  logic   queue_empty;

  b64enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .queue_full (queue_full),
    .push       (push),
    .push_group (push_group)
  );

  b64enc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .pop_group  (pop_group),
    .full       (queue_full),
    .empty      (queue_empty)
  );

  b64enc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .pop_group   (pop_group),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full)
    else $error("group pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !queue_empty)
    else $error("group popped from an empty queue");

  a_end_on_group_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("stream end flagged inside a group");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

// ===== test/base64_stream_encoder_tb.sv =====
`timescale 1ns / 1ps
module base64_stream_encoder_tb;

  import b64enc_pkg::*;

  localparam logic [511:0] B64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int MaxPrinted = 20;

  typedef struct {
    logic [7:0] ch;
    logic       group_end;
    logic       msg_end;
  } b64_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  b64_char_t  expected_chars[$];
  b64_char_t  want;
  logic [7:0] held_first = 8'h00;
  logic [7:0] held_second = 8'h00;
  logic [1:0] held_count = 2'd0;

  int tx_max_gap = 0;
  int rx_max_stall = 0;
  int rx_hold_cycles = 0;
  int bytes_sent = 0;
  int chars_checked = 0;
  int messages_done = 0;
  int error_count = 0;

  base64_stream_encoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    int idx;
    idx = 63 - int'(v);
    return B64Alphabet[idx * 8 +: 8];
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic group_end, input logic msg_end);
    b64_char_t item;
    item.ch = ch;
    item.group_end = group_end;
    item.msg_end = msg_end;
    expected_chars.push_back(item);
  endtask

  task automatic predict_chars(input logic [7:0] b, input logic fin);
    logic [23:0] bits;
    logic [7:0]  c2;
    logic [7:0]  c3;
    if (!fin && held_count == 2'd0) begin
      held_first = b;
      held_count = 2'd1;
    end else if (!fin && held_count == 2'd1) begin
      held_second = b;
      held_count = 2'd2;
    end else begin
      case (held_count)
        2'd0: bits = {b, 16'h0000};
        2'd1: bits = {held_first, b, 8'h00};
        default: bits = {held_first, held_second, b};
      endcase
      c2 = (held_count == 2'd0) ? PadChar : sextet_char(bits[11:6]);
      c3 = (held_count >= 2'd2) ? sextet_char(bits[5:0]) : PadChar;
      push_char(sextet_char(bits[23:18]), 1'b0, 1'b0);
      push_char(sextet_char(bits[17:12]), 1'b0, 1'b0);
      push_char(c2, 1'b0, 1'b0);
      push_char(c3, 1'b1, fin);
      held_first = 8'h00;
      held_second = 8'h00;
      held_count = 2'd0;
    end
  endtask

  task automatic report_error(input string msg);
    if (error_count < MaxPrinted) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Entered and left at a falling edge; tvalid stays high when the next
  // byte follows without a gap.
  task automatic send_byte(input logic [7:0] data, input logic fin);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = data;
    s_tlast = fin;
    do @(posedge clk); while (!s_tready);
    predict_chars(data, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 1; i <= len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len);
    end
  endtask

  task automatic wait_for_drain();
    s_tvalid = 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    tx_max_gap = 3;
    rx_max_stall = 3;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h4D, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h61, 1'b1);
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int n, input int max_gap, input int max_stall);
    int start;
    start = bytes_sent;
    tx_max_gap = max_gap;
    rx_max_stall = max_stall;
    while (bytes_sent - start < n) begin
      if ($urandom_range(0, 4) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        send_message($urandom_range(1, 10));
      end
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    wait_for_drain();
  endtask

  task automatic test_output_hold_off();
    tx_max_gap = 0;
    rx_max_stall = 0;
    rx_hold_cycles = 120;
    repeat (8) send_message($urandom_range(3, 7));
    wait_for_drain();
  endtask

  task automatic test_drained_pauses();
    tx_max_gap = 2;
    rx_max_stall = 6;
    repeat (10) begin
      send_message($urandom_range(1, 6));
      wait_for_drain();
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        stall_left = $urandom_range(0, rx_max_stall);
      end
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        m_tready = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_chars.size() == 0) begin
        report_error($sformatf("unexpected character %02h", m_tdata));
      end else begin
        want = expected_chars.pop_front();
        if (m_tdata !== want.ch) begin
          report_error($sformatf("character %0d: out_char expected %02h, got %02h",
                                 chars_checked, want.ch, m_tdata));
        end
        if (m_tlast !== want.group_end) begin
          report_error($sformatf("character %0d: run_last expected %0b, got %0b",
                                 chars_checked, want.group_end, m_tlast));
        end
        if (m_tuser !== want.msg_end) begin
          report_error($sformatf("character %0d: stream_end expected %0b, got %0b",
                                 chars_checked, want.msg_end, m_tuser));
        end
      end
      chars_checked++;
      if (m_tuser === 1'b1) begin
        messages_done++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d characters still expected", expected_chars.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_traffic(60, 0, 0);
    test_random_traffic(100, 12, 12);
    test_output_hold_off();
    test_drained_pauses();
    repeat (16) @(posedge clk);
    $display("Encoded %0d bytes into %0d characters over %0d messages.",
             bytes_sent, chars_checked, messages_done);
    $display("Covered padded and full groups, back-to-back and idle traffic, hold-off.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Mismatches: %0d", error_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/b64enc_pkg.sv
rtl/core/b64enc_front.sv
rtl/core/b64enc_fifo.sv
rtl/core/b64enc_back.sv
rtl/core/base64_stream_encoder.sv
test/base64_stream_encoder_tb.sv
